// ===== sv/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sxfp_pkg.sv =====
package sxfp_pkg;

  localparam logic [7:0] SyncByte = 8'hFF;

  typedef enum logic [5:0] {
    PH_SYNC1 = 6'b000001,
    PH_SYNC2 = 6'b000010,
    PH_CMD   = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_LEN   = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_CHECK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_GOOD  = 2'd1,
    ST_BAD   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    kind_t      byte_kind;
    logic       frame_last;
    status_t    frame_status;
  } result_t;

  // handshake between the input register and the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } held_byte_t;

endpackage

// ===== sv/sxfp_in_if.sv =====
interface sxfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sxfp_out_if.sv =====
interface sxfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [1:0] byte_kind;
  logic       frame_last;
  logic [1:0] frame_status;

  modport source (output valid, output byte_value, output byte_kind, output frame_last,
                  output frame_status, input ready);
  modport sink (input valid, input byte_value, input byte_kind, input frame_last,
                input frame_status, output ready);
endinterface

// ===== sv/sync_length_xor_frame_parser_top.sv =====
// Frame deframer for a serial byte stream: one received byte per in_ch beat. It hunts for
// two 0xFF sync bytes, then passes on the command byte, the length byte and that many
// payload bytes as out_ch beats tagged with their kind, and closes the frame with the
// received checksum byte marked good or mismatch against the XOR of command, length and
// payload. A zero length closes the frame on the length beat with status dropped. Sync
// bytes and bytes between frames produce no beat. Bad frames are not filtered here: the
// consumer discards them by the status on the closing beat. The block takes one byte per
// clock cycle while out_ch is not stalled; a byte goes through an input register and then
// a result register, which holds its beat on out_ch.
module sync_length_xor_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  sxfp_in_if.sink     in_ch,
  sxfp_out_if.source  out_ch
);

  sxfp_pkg::held_byte_t held;
  sxfp_pkg::result_t    res;
  sxfp_pkg::result_t    out_res;
  logic                 take;
  logic                 res_load;
  logic                 out_free;

  sxfp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_rx_byte (in_ch.rx_byte),
    .in_ready   (in_ch.ready),
    .take       (take),
    .held       (held)
  );

  sxfp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .held     (held),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res      (res)
  );

  sxfp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.byte_value   = out_res.byte_value;
  assign out_ch.byte_kind    = out_res.byte_kind;
  assign out_ch.frame_last   = out_res.frame_last;
  assign out_ch.frame_status = out_res.frame_status;

endmodule

// ===== sv/sxfp_in_stage.sv =====
module sxfp_in_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [7:0]               in_rx_byte,
  output logic                     in_ready,
  input  logic                     take,
  output sxfp_pkg::held_byte_t     held
);

  logic       valid_r;
  logic [7:0] byte_r;

  // the slot frees up in the same cycle the parser consumes it
  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign held.valid   = valid_r;
  assign held.rx_byte = byte_r;

endmodule

// ===== sv/sxfp_parser.sv =====
module sxfp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sxfp_pkg::held_byte_t  held,
  input  logic                  out_free,
  output logic                  take,
  output logic                  res_load,
  output sxfp_pkg::result_t     res
);

  sxfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       remain_r, remain_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             emit;
  logic [7:0]       b;
  logic [7:0]       remain_dec;

  assign b          = held.rx_byte;
  assign remain_dec = remain_r - 8'd1;

  always_comb begin
    phase_nxt        = sxfp_pkg::PH_SYNC1;
    remain_nxt       = remain_r;
    xor_nxt          = xor_r;
    emit             = 1'b0;
    res.byte_value   = b;
    res.byte_kind    = sxfp_pkg::KIND_CMD;
    res.frame_last   = 1'b0;
    res.frame_status = sxfp_pkg::ST_BUSY;
    unique case (phase_r)
      sxfp_pkg::PH_SYNC2: begin
        if (b == sxfp_pkg::SyncByte) begin
          phase_nxt  = sxfp_pkg::PH_CMD;
          remain_nxt = 8'd0;
          xor_nxt    = 8'd0;
        end
      end
      sxfp_pkg::PH_CMD: begin
        xor_nxt   = xor_r ^ b;
        phase_nxt = sxfp_pkg::PH_LEN;
        emit      = 1'b1;
      end
      sxfp_pkg::PH_LEN: begin
        xor_nxt       = xor_r ^ b;
        remain_nxt    = b;
        emit          = 1'b1;
        res.byte_kind = sxfp_pkg::KIND_LEN;
        if (b == 8'd0) begin
          res.frame_last   = 1'b1;
          res.frame_status = sxfp_pkg::ST_EMPTY;
        end else begin
          phase_nxt = sxfp_pkg::PH_DATA;
        end
      end
      sxfp_pkg::PH_DATA: begin
        xor_nxt       = xor_r ^ b;
        remain_nxt    = remain_dec;
        emit          = 1'b1;
        res.byte_kind = sxfp_pkg::KIND_DATA;
        phase_nxt     = (remain_dec == 8'd0) ? sxfp_pkg::PH_CHECK : sxfp_pkg::PH_DATA;
      end
      sxfp_pkg::PH_CHECK: begin
        emit             = 1'b1;
        res.byte_kind    = sxfp_pkg::KIND_CHECK;
        res.frame_last   = 1'b1;
        res.frame_status = (b == xor_r) ? sxfp_pkg::ST_GOOD : sxfp_pkg::ST_BAD;
      end
      default: begin
        // first sync hunt, also recovers from any stray phase code
        phase_nxt = (b == sxfp_pkg::SyncByte) ? sxfp_pkg::PH_SYNC2 : sxfp_pkg::PH_SYNC1;
      end
    endcase
  end

  // bytes without a result never wait on the output side
  assign take     = held.valid && (!emit || out_free);
  assign res_load = take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sxfp_pkg::PH_SYNC1;
      remain_r <= 8'd0;
      xor_r    <= 8'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      xor_r    <= xor_nxt;
    end
  end

endmodule

// ===== sv/sxfp_out_stage.sv =====
module sxfp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_load,
  input  sxfp_pkg::result_t  res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output sxfp_pkg::result_t  out_res
);

  logic              valid_r;
  sxfp_pkg::result_t res_r;

  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && out_free) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== sv/sxfp_checker.sv =====
`include "assert_macros.svh"

module sxfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_value,
  input logic [1:0] out_byte_kind,
  input logic       out_frame_last,
  input logic [1:0] out_frame_status
);

  // frames close only on a length or checksum beat
  `ASSERT_RST(a_last_kind,
    out_valid && out_frame_last |->
      out_byte_kind == sxfp_pkg::KIND_LEN || out_byte_kind == sxfp_pkg::KIND_CHECK,
    "frame closed on a command or payload beat")

  // status is reported exactly on the closing beat
  `ASSERT_RST(a_status_last,
    out_valid |-> out_frame_last == (out_frame_status != sxfp_pkg::ST_BUSY),
    "status and frame_last disagree")

  // dropped status belongs to a zero length byte
  `ASSERT_RST(a_empty_len,
    out_valid && out_frame_status == sxfp_pkg::ST_EMPTY |->
      out_byte_kind == sxfp_pkg::KIND_LEN && out_byte_value == 8'd0,
    "dropped status on a nonzero length")

  // a stalled beat holds
  `ASSERT_RST(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_byte_value) &&
      $stable(out_byte_kind) && $stable(out_frame_last) && $stable(out_frame_status),
    "result changed while stalled")

  // nothing comes out right after reset
  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result beat right after reset")

endmodule

bind sync_length_xor_frame_parser_top sxfp_checker u_sxfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_byte_value   (out_ch.byte_value),
  .out_byte_kind    (out_ch.byte_kind),
  .out_frame_last   (out_ch.frame_last),
  .out_frame_status (out_ch.frame_status)
);
